// ===== rtl/sgk_pkg.sv =====
package sgk_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned RowIdxW = 6;

  typedef struct packed {
    logic signed [KeyW-1:0] label_key;
    logic                   last_row;
  } sgk_in_t;

  typedef struct packed {
    logic [RowIdxW-1:0] row_index;
    logic               last_index;
    logic               overflow;
  } sgk_out_t;

  // One result offered by the grouping engine to the output register
  typedef struct packed {
    logic     valid;
    sgk_out_t item;
  } sgk_emit_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEEK,
    ST_HEAD,
    ST_SCAN
  } sgk_state_e;

endpackage

// ===== rtl/sgk_ram.sv =====
module sgk_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sgk_grouper.sv =====
module sgk_grouper #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sgk_pkg::sgk_in_t  in_data_i,
  input  logic              slot_free_i,
  output sgk_pkg::sgk_emit_t emit_o
);

  import sgk_pkg::*;

  localparam int unsigned IdxW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ROWS + 1);
  // each entry holds the row's taken mark above its key
  localparam int unsigned EntW = KeyW + 1;

  sgk_state_e          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [IdxW-1:0]     i_q, i_d;
  logic [CntW-1:0]     j_q, j_d;
  logic [CntW-1:0]     emit_cnt_q, emit_cnt_d;
  logic [KeyW-1:0]     key_ref_q, key_ref_d;
  logic                p_valid_q, p_valid_d;
  logic [IdxW-1:0]     p_idx_q, p_idx_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [EntW-1:0] ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [EntW-1:0] ram_rdata;
  logic            ram_rtaken;
  logic [KeyW-1:0] ram_rkey;

  logic is_final;
  logic match;
  logic stall;

  sgk_ram #(
    .Width (EntW),
    .Depth (MAX_ROWS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_rtaken = ram_rdata[KeyW];
  assign ram_rkey   = ram_rdata[KeyW-1:0];

  assign is_final = (CntW'(emit_cnt_q + CntW'(1)) == cnt_q);
  assign match    = p_valid_q && !ram_rtaken && (ram_rkey == key_ref_q);
  assign stall    = match && !slot_free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      emit_cnt_q <= '0;
      p_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      i_q        <= i_d;
      j_q        <= j_d;
      emit_cnt_q <= emit_cnt_d;
      p_valid_q  <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_ref_q <= key_ref_d;
    p_idx_q   <= p_idx_d;
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    emit_cnt_d = emit_cnt_q;
    key_ref_d  = key_ref_q;
    p_valid_d  = p_valid_q;
    p_idx_d    = p_idx_q;

    in_ready_o = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[IdxW-1:0];
    // loading a row clears its taken mark
    ram_wdata  = {1'b0, in_data_i.label_key};
    ram_re     = 1'b0;
    ram_raddr  = i_q;

    emit_o.valid           = 1'b0;
    emit_o.item.row_index  = RowIdxW'(i_q);
    emit_o.item.last_index = is_final;
    emit_o.item.overflow   = ovf_q;

    case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cnt_q < CntW'(MAX_ROWS)) begin
            ram_we = 1'b1;
            cnt_d  = CntW'(cnt_q + CntW'(1));
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last_row) begin
            i_d     = '0;
            state_d = ST_SEEK;
          end
        end
      end

      ST_SEEK: begin
        ram_re  = 1'b1;
        state_d = ST_HEAD;
      end

      ST_HEAD: begin
        if (ram_rtaken) begin
          // skip a row already taken by an earlier group
          i_d       = IdxW'(i_q + IdxW'(1));
          ram_re    = 1'b1;
          ram_raddr = IdxW'(i_q + IdxW'(1));
        end else if (slot_free_i) begin
          emit_o.valid  = 1'b1;
          ram_we        = 1'b1;
          ram_waddr     = i_q;
          ram_wdata     = {1'b1, ram_rkey};
          emit_cnt_d    = CntW'(emit_cnt_q + CntW'(1));
          key_ref_d     = ram_rkey;
          j_d           = CntW'(CntW'(i_q) + CntW'(1));
          p_valid_d     = 1'b0;
          state_d       = ST_SCAN;
          if (is_final) begin
            state_d    = ST_LOAD;
            cnt_d      = '0;
            ovf_d      = 1'b0;
            emit_cnt_d = '0;
          end
        end
      end

      ST_SCAN: begin
        if (!stall) begin
          if (match) begin
            emit_o.valid          = 1'b1;
            emit_o.item.row_index = RowIdxW'(p_idx_q);
            ram_we                = 1'b1;
            ram_waddr             = p_idx_q;
            ram_wdata             = {1'b1, key_ref_q};
            emit_cnt_d            = CntW'(emit_cnt_q + CntW'(1));
          end
          if (match && is_final) begin
            state_d    = ST_LOAD;
            cnt_d      = '0;
            ovf_d      = 1'b0;
            emit_cnt_d = '0;
            p_valid_d  = 1'b0;
          end else if (j_q < cnt_q) begin
            // issue the next candidate; it is compared in the following cycle
            ram_re    = 1'b1;
            ram_raddr = j_q[IdxW-1:0];
            p_valid_d = 1'b1;
            p_idx_d   = j_q[IdxW-1:0];
            j_d       = CntW'(j_q + CntW'(1));
          end else begin
            p_valid_d = 1'b0;
            i_d       = IdxW'(i_q + IdxW'(1));
            state_d   = ST_SEEK;
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== rtl/stable_group_by_key_core.sv =====
// Stable grouping of row indices by equal 32-bit key.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one key per transfer,
// loaded as rows 0, 1, 2, ... One row is taken per cycle. The transfer with
// last_row set ends the batch; rows beyond MAX_ROWS are dropped and flag
// overflow on every result of that batch.
// Output channel (out_valid_o/out_ready_i/out_data_o): after the last row
// the block emits every loaded row index once, each untaken row followed by
// the later untaken rows with the same key. last_index marks the final one.
// While regrouping, the input is not ready; loading of the next batch starts
// as soon as the final result sits in the output register.
// Regrouping skips each already taken row, reads each group head and then
// compares every later row against it; all keys differing is the worst case.
// Its speed is set by the single read port of the key memory, which sees one
// candidate row per cycle while the receiver does not stall the scan.
// After the last row's transfer row 0 is read and then offered as the first index.
// A stalled receiver holds the output register and freezes the scan.
// Reset empties the batch. The key memory is not cleared: each entry keeps a
// taken mark beside its key, cleared as the row is loaded, and only rows
// written in the current batch are ever read.
module stable_group_by_key_core #(
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sgk_pkg::sgk_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sgk_pkg::sgk_out_t out_data_o
);

  import sgk_pkg::*;

  sgk_emit_t emit;
  logic      slot_free;
  logic      out_valid_q, out_valid_d;
  sgk_out_t  out_data_q, out_data_d;

  assign slot_free = !out_valid_q || out_ready_i;

  sgk_grouper #(
    .MAX_ROWS (MAX_ROWS)
  ) u_grouper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (emit.valid) begin
      out_valid_d = 1'b1;
      out_data_d  = emit.item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
